// ===== sv/tclc_pkg.sv =====
// Shared types, widths and weight constants for the two-channel lux calculator.
`default_nettype none

package tclc_pkg;

	// Default parameter values.
	localparam int RATIO_FRAC_BITS_DEF   = 16;
	localparam int POWER_TABLE_DEPTH_DEF = 256;
	localparam int LUX_FRAC_BITS_DEF     = 10;

	// Fixed field widths.
	localparam int COUNT_W    = 16;
	localparam int LUX_W      = 22;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	// Internal datapath widths.
	localparam int POWER_W   = 16;  // ratio^1.4 in Q16
	localparam int WEIGHT_W  = 28;  // per-band weighted difference
	localparam int NUM_W     = 44;  // numerator over WEIGHT_DEN * 2^16
	localparam int WIDE_W    = 60;  // numerator after the lux fraction shift
	localparam int LUX_REM_W = 39;  // holds WEIGHT_DEN * 2^LUX_W - 1
	localparam int EDGE_W    = 24;  // band edge cross products
	localparam int KW        = 12;  // band weight constants

	localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};
	localparam longint WEIGHT_DEN = 100000;

	// Division by WEIGHT_DEN = 2^5 * 3125 for a numerator below 2^LUX_REM_W: drop the five
	// low bits, then multiply by ceil(2^46 / 3125) and keep the bits above 2^46. The
	// rounding error of the reciprocal stays below one quotient step for 34-bit inputs.
	localparam int RECIP_PRE    = 5;
	localparam int RECIP_IN_W   = LUX_REM_W - RECIP_PRE;
	localparam int RECIP_LO_W   = 18;
	localparam int RECIP_HI_W   = 17;
	localparam logic [RECIP_LO_W+RECIP_HI_W-1:0] RECIP_M = 35'd22517998137;
	localparam int RECIP_SHIFT  = 46;
	localparam int RECIP_PROD_W = RECIP_SHIFT + LUX_W;

	// Band edges as ir * EDGE_DEN <= bb * edge.
	localparam int EDGE_DEN  = 100;
	localparam int LOW_EDGE  = 50;
	localparam int MID_EDGE  = 61;
	localparam int HIGH_EDGE = 80;
	localparam int TOP_EDGE  = 130;

	// Weights scaled by WEIGHT_DEN; the low band broadband weight is also scaled by 2^16.
	localparam logic [WEIGHT_W-1:0] LOW_BB_WEIGHT = WEIGHT_W'(3040 * 65536);
	localparam int LOW_P_WEIGHT = 6200;
	localparam logic [KW-1:0] MID_BB_WEIGHT  = KW'(2240);
	localparam logic [KW-1:0] MID_IR_WEIGHT  = KW'(3100);
	localparam logic [KW-1:0] HIGH_BB_WEIGHT = KW'(1280);
	localparam logic [KW-1:0] HIGH_IR_WEIGHT = KW'(1530);
	localparam logic [KW-1:0] TOP_BB_WEIGHT  = KW'(146);
	localparam logic [KW-1:0] TOP_IR_WEIGHT  = KW'(112);

	typedef enum logic [2:0] {
		BAND_NONE,
		BAND_LOW,
		BAND_MID,
		BAND_HIGH,
		BAND_TOP
	} tclc_band_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bb;
		logic [COUNT_W-1:0] ir;
		tclc_band_t         band;
		logic               zero;
	} tclc_meas_t;

	typedef struct packed {
		logic zero;
		logic sat;
	} tclc_flags_t;

endpackage

`default_nettype wire

// ===== sv/tclc_div_cell.sv =====
// One restoring-division cell: compare, conditional subtract, one quotient bit.
`default_nettype none

module tclc_div_cell #(
	parameter int REM_W = 17,
	parameter int QUO_W = 16,
	parameter int PAY_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REM_W-1:0] in_rem,
	input  logic [REM_W-1:0] in_den,
	input  logic [QUO_W-1:0] in_quo,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [REM_W-1:0] out_rem,
	output logic [QUO_W-1:0] out_quo,
	output logic [PAY_W-1:0] out_pay
);

	logic             valid_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [PAY_W-1:0] pay_q;
	logic             take;

	assign take     = in_rem >= in_den;
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q <= take ? in_rem - in_den : in_rem;
			quo_q <= {in_quo[QUO_W-2:0], take};
			pay_q <= in_pay;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_quo   = quo_q;
	assign out_pay   = pay_q;

endmodule

`default_nettype wire

// ===== sv/tclc_weight.sv =====
// Weight stages: power table lookup, band weights, numerator, saturation and lux division.
`default_nettype none

module tclc_weight #(
	parameter int RATIO_FRAC_BITS   = tclc_pkg::RATIO_FRAC_BITS_DEF,
	parameter int POWER_TABLE_DEPTH = tclc_pkg::POWER_TABLE_DEPTH_DEF,
	parameter int LUX_FRAC_BITS     = tclc_pkg::LUX_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tclc_pkg::tclc_meas_t            in_meas,
	input  logic [RATIO_FRAC_BITS-1:0]      in_ratio,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tclc_pkg::LUX_W-1:0]      out_lux,
	output tclc_pkg::tclc_flags_t           out_flags
);

	import tclc_pkg::*;

	localparam int RomDepth = POWER_TABLE_DEPTH + 1;
	localparam int TwoDepth = 2 * POWER_TABLE_DEPTH;
	localparam int DW       = $clog2(TwoDepth + 1);
	localparam int IW       = $clog2(RomDepth);
	localparam int PW       = RATIO_FRAC_BITS + DW;
	localparam int LoProdW  = RECIP_IN_W + RECIP_LO_W;
	localparam int HiProdW  = RECIP_IN_W + RECIP_HI_W;
	localparam logic [WIDE_W-1:0] SatLimit = WIDE_W'(WEIGHT_DEN) << LUX_W;

	typedef logic [POWER_W-1:0] rom_t [RomDepth];

	// Entry i holds r^1.4 in Q16 for r = i / (2 * depth), using a bitwise fifth root.
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] rq;
		logic [63:0] tgt;
		logic [63:0] s;
		logic [63:0] t;
		logic [63:0] t5;
		for (int i = 0; i < RomDepth; i++) begin
			rq  = (64'(i) << 16) / TwoDepth;
			tgt = (rq * rq) << 28;
			s   = 64'd0;
			for (int b = 11; b >= 0; b--) begin
				t  = s | (64'd1 << b);
				t5 = t * t * t * t * t;
				if (t5 <= tgt) begin
					s = t;
				end
			end
			rom[i] = POWER_W'((rq * s) >> 12);
		end
		return rom;
	endfunction

	localparam rom_t PowerRom = build_rom();

	// Stage handshake.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7     = !v_s7 || out_ready;
	assign rdy6     = !v_s6 || rdy7;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// Stage 1: table index from the ratio, plain weighted difference for the upper bands.
	logic [RATIO_FRAC_BITS-1:0] ratio_low;
	logic [PW-1:0]              idx_prod;
	logic [KW-1:0]              k_bb, k_ir;
	logic [WEIGHT_W-1:0]        a_bb, b_ir, diff;

	always_comb begin
		ratio_low = (in_meas.band == BAND_LOW) ? in_ratio : '0;
		idx_prod  = PW'(ratio_low) * PW'(TwoDepth);
		case (in_meas.band)
			BAND_MID: begin
				k_bb = MID_BB_WEIGHT;
				k_ir = MID_IR_WEIGHT;
			end
			BAND_HIGH: begin
				k_bb = HIGH_BB_WEIGHT;
				k_ir = HIGH_IR_WEIGHT;
			end
			BAND_TOP: begin
				k_bb = TOP_BB_WEIGHT;
				k_ir = TOP_IR_WEIGHT;
			end
			default: begin
				k_bb = '0;
				k_ir = '0;
			end
		endcase
		a_bb = WEIGHT_W'(k_bb) * WEIGHT_W'(in_meas.bb);
		b_ir = WEIGHT_W'(k_ir) * WEIGHT_W'(in_meas.ir);
		diff = (a_bb > b_ir) ? a_bb - b_ir : '0;
	end

	tclc_band_t              band_s1, band_s2, band_s3;
	logic [COUNT_W-1:0]      bb_s1, bb_s2, bb_s3;
	logic                    zero_s1, zero_s2, zero_s3, zero_s4;
	logic [IW-1:0]           idx_s1;
	logic [WEIGHT_W-1:0]     diff_s1, diff_s2;
	logic [POWER_W-1:0]      p_s2;
	logic [WEIGHT_W-1:0]     w_s3;
	logic [NUM_W-1:0]        x_s4;
	logic [RECIP_IN_W-1:0]   scaled_s5;
	tclc_flags_t             flags_s5, flags_s6, flags_s7;
	logic [LoProdW-1:0]      pp_lo_s6;
	logic [HiProdW-1:0]      pp_hi_s6;
	logic [LUX_W-1:0]        lux_s7;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			band_s1 <= in_meas.band;
			bb_s1   <= in_meas.bb;
			zero_s1 <= in_meas.zero;
			idx_s1  <= idx_prod[RATIO_FRAC_BITS+IW-1:RATIO_FRAC_BITS];
			diff_s1 <= diff;
		end
	end

	// Stage 2: registered table read.
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			band_s2 <= band_s1;
			bb_s2   <= bb_s1;
			zero_s2 <= zero_s1;
			diff_s2 <= diff_s1;
			p_s2    <= PowerRom[idx_s1];
		end
	end

	// Stage 3: low band broadband weight, 0.0304 - 0.062 * r^1.4; the upper bands pass on their difference.
	logic [WEIGHT_W:0]   p_prod;
	logic [WEIGHT_W-1:0] coef;
	logic [WEIGHT_W-1:0] w_next;

	always_comb begin
		p_prod = (WEIGHT_W+1)'(p_s2) * (WEIGHT_W+1)'(LOW_P_WEIGHT);
		coef   = (p_prod < (WEIGHT_W+1)'(LOW_BB_WEIGHT)) ?
			LOW_BB_WEIGHT - p_prod[WEIGHT_W-1:0] : '0;
		case (band_s2)
			BAND_LOW:  w_next = coef;
			BAND_MID:  w_next = diff_s2;
			BAND_HIGH: w_next = diff_s2;
			BAND_TOP:  w_next = diff_s2;
			default:   w_next = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			band_s3 <= band_s2;
			bb_s3   <= bb_s2;
			zero_s3 <= zero_s2;
			w_s3    <= w_next;
		end
	end

	// Stage 4: numerator over WEIGHT_DEN * 2^16 for every band.
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			zero_s4 <= zero_s3;
			if (band_s3 == BAND_LOW) begin
				x_s4 <= NUM_W'(bb_s3) * NUM_W'(w_s3);
			end else begin
				x_s4 <= {w_s3, 16'h0000};
			end
		end
	end

	// Stage 5: apply the lux fraction scale, drop the Q16 part, check for overflow.
	// The five low bits are dropped here as the power-of-two part of the divisor.
	logic [WIDE_W-1:0] y_wide;
	logic              sat;

	assign y_wide = (WIDE_W'(x_s4) << LUX_FRAC_BITS) >> 16;
	assign sat    = y_wide >= SatLimit;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			scaled_s5     <= sat ? '0 : y_wide[LUX_REM_W-1:RECIP_PRE];
			flags_s5.sat  <= sat;
			flags_s5.zero <= zero_s4;
		end
	end

	// Stage 6: two partial products of the numerator with the reciprocal of 3125.
	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			pp_lo_s6 <= LoProdW'(scaled_s5) * LoProdW'(RECIP_M[RECIP_LO_W-1:0]);
			pp_hi_s6 <= HiProdW'(scaled_s5) *
				HiProdW'(RECIP_M[RECIP_LO_W+RECIP_HI_W-1:RECIP_LO_W]);
			flags_s6 <= flags_s5;
		end
	end

	// Stage 7: sum the partial products and keep the quotient bits; saturate on overflow.
	logic [RECIP_PROD_W-1:0] recip_prod;

	assign recip_prod = RECIP_PROD_W'({pp_hi_s6, RECIP_LO_W'(0)}) + RECIP_PROD_W'(pp_lo_s6);

	always_ff @(posedge clk) begin
		if (rdy7 && v_s6) begin
			lux_s7   <= flags_s6.sat ? LUX_MAX : recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
			flags_s7 <= flags_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_lux   = lux_s7;
	assign out_flags = flags_s7;

endmodule

`default_nettype wire

// ===== sv/two_channel_lux_calculator.sv =====
// Top level of the two-channel lux calculator: ratio divider and weight stages.
//
// Usage: each input transfer on the s_ group carries one pair of raw sensor counts,
// broadband in s_tdata[15:0] and infrared in s_tdata[31:16]. Each input transfer yields
// exactly one output transfer on the m_ group: lux in m_tdata[21:0], unsigned with
// LUX_FRAC_BITS fraction bits, and a flag on m_tuser that is set when the broadband
// count was zero. Results leave in the order the counts came in.
// The path runs through one divider cell per quotient bit of the ratio and then seven
// weight stages, the last two of which divide by the weight denominator through a split
// reciprocal product.
// Throughput is one transfer per cycle while the receiver takes results; every stage is
// a register with its own valid bit, so the rate is set by the single compare and
// subtract in each divider cell and the multipliers of one weight stage.
// When the receiver stalls, the last stage holds its result and the stages behind it keep
// filling until each holds an item; s_tready falls only once the whole chain is full.
// Reset clears every valid bit; no result is shown until new counts arrive, and the
// block accepts counts straight after reset, since every stage is then empty.
`default_nettype none

module two_channel_lux_calculator #(
	parameter int RATIO_FRAC_BITS   = tclc_pkg::RATIO_FRAC_BITS_DEF,
	parameter int POWER_TABLE_DEPTH = tclc_pkg::POWER_TABLE_DEPTH_DEF,
	parameter int LUX_FRAC_BITS     = tclc_pkg::LUX_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tclc_pkg::IN_DATA_W-1:0]  s_tdata,  // broadband_count, infrared_count
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tclc_pkg::OUT_DATA_W-1:0] m_tdata,  // lux_value, zero padding
	output logic                            m_tuser   // zero_broadband
);

	import tclc_pkg::*;

	localparam int RatioRemW = COUNT_W + 1;
	localparam int MeasW     = $bits(tclc_meas_t);

	// Input side: split the counts and pick the band by exact cross products,
	// so a truncated ratio never moves a pair across a band edge.
	logic [COUNT_W-1:0] bb_in, ir_in, ir_clip;
	logic [EDGE_W-1:0]  ir_scaled;
	tclc_meas_t         meas_in;

	assign bb_in     = s_tdata[COUNT_W-1:0];
	assign ir_in     = s_tdata[2*COUNT_W-1:COUNT_W];
	assign ir_scaled = EDGE_W'(ir_in) * EDGE_W'(EDGE_DEN);
	// The ratio matters only below one half, where infrared is below broadband.
	assign ir_clip   = (ir_in < bb_in) ? ir_in : '0;

	always_comb begin
		meas_in.bb   = bb_in;
		meas_in.ir   = ir_in;
		meas_in.zero = (bb_in == '0);
		if (bb_in == '0 || ir_in == '0) begin
			meas_in.band = BAND_NONE;
		end else if (ir_scaled <= EDGE_W'(bb_in) * EDGE_W'(LOW_EDGE)) begin
			meas_in.band = BAND_LOW;
		end else if (ir_scaled <= EDGE_W'(bb_in) * EDGE_W'(MID_EDGE)) begin
			meas_in.band = BAND_MID;
		end else if (ir_scaled <= EDGE_W'(bb_in) * EDGE_W'(HIGH_EDGE)) begin
			meas_in.band = BAND_HIGH;
		end else if (ir_scaled <= EDGE_W'(bb_in) * EDGE_W'(TOP_EDGE)) begin
			meas_in.band = BAND_TOP;
		end else begin
			meas_in.band = BAND_NONE;
		end
	end

	// Ratio divider: one cell per fraction bit of infrared / broadband. Position k
	// is the hand-off between cell k-1 and cell k; position 0 is the input port.
	logic                       r_valid [RATIO_FRAC_BITS+1];
	logic                       r_ready [RATIO_FRAC_BITS+1];
	logic [RatioRemW-1:0]       r_rem   [RATIO_FRAC_BITS+1];
	logic [RATIO_FRAC_BITS-1:0] r_quo   [RATIO_FRAC_BITS+1];
	logic [MeasW-1:0]           r_pay   [RATIO_FRAC_BITS+1];

	assign r_valid[0] = s_tvalid;
	assign s_tready   = r_ready[0];
	assign r_rem[0]   = RatioRemW'(ir_clip);
	assign r_quo[0]   = '0;
	assign r_pay[0]   = meas_in;

	for (genvar k = 0; k < RATIO_FRAC_BITS; k++) begin : g_ratio
		tclc_meas_t meas_k;
		assign meas_k = tclc_meas_t'(r_pay[k]);

		tclc_div_cell #(
			.REM_W (RatioRemW),
			.QUO_W (RATIO_FRAC_BITS),
			.PAY_W (MeasW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (r_valid[k]),
			.in_ready  (r_ready[k]),
			.in_rem    ({r_rem[k][COUNT_W-1:0], 1'b0}),
			.in_den    (RatioRemW'(meas_k.bb)),
			.in_quo    (r_quo[k]),
			.in_pay    (r_pay[k]),
			.out_valid (r_valid[k+1]),
			.out_ready (r_ready[k+1]),
			.out_rem   (r_rem[k+1]),
			.out_quo   (r_quo[k+1]),
			.out_pay   (r_pay[k+1])
		);
	end

	// Weight stages turn the band, counts and ratio into lux; the last stage is the
	// output register and already holds the saturated value.
	tclc_flags_t      out_flags;
	logic [LUX_W-1:0] lux;

	tclc_weight #(
		.RATIO_FRAC_BITS   (RATIO_FRAC_BITS),
		.POWER_TABLE_DEPTH (POWER_TABLE_DEPTH),
		.LUX_FRAC_BITS     (LUX_FRAC_BITS)
	) u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid[RATIO_FRAC_BITS]),
		.in_ready  (r_ready[RATIO_FRAC_BITS]),
		.in_meas   (tclc_meas_t'(r_pay[RATIO_FRAC_BITS])),
		.in_ratio  (r_quo[RATIO_FRAC_BITS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_lux   (lux),
		.out_flags (out_flags)
	);

	assign m_tdata = {(OUT_DATA_W - LUX_W)'(0), lux};
	assign m_tuser = out_flags.zero;

	// An empty or draining output register means every cell can take data.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while the output side was free");

	// A zero broadband count must give zero lux, never a saturated value.
	a_zero_lux: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[LUX_W-1:0] == '0))
		else $error("nonzero lux with zero broadband count");

	// The saturation path never fires for a zero broadband count.
	a_zero_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_flags.zero) |-> !out_flags.sat)
		else $error("saturation flagged for a zero broadband count");

endmodule

`default_nettype wire
